// ===== sv/hpack_huffman_string_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// hpack huffman string decoder assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef HPACK_HUFFMAN_STRING_DECODER_MACROS_SVH
`define HPACK_HUFFMAN_STRING_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HPD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpd assertion failed");
// next-cycle implication
`define HPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpd assertion failed");
`else
`define HPD_ASSERT_NOW(lbl, ante, cons)
`define HPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/hpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_pkg
// Canonical code tables and status codes of the hpack huffman decoder.
// ----------------------------------------------------------------------------
package hpd_pkg;

	localparam int CODE_BITS = 30;
	localparam int MAX_PAD   = 7;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EOS     = 3'd1;
	localparam logic [2:0] ST_PADDING = 3'd2;
	localparam logic [2:0] ST_OUT_LEN = 3'd3;
	localparam logic [2:0] ST_IN_LEN  = 3'd4;

	localparam logic [8:0] EOS_RANK = 9'd256;

	// per code length: first code, number of codes, rank of the first code
	typedef struct packed {
		logic [CODE_BITS-1:0] first;
		logic [8:0]           count;
		logic [8:0]           offset;
	} len_info_t;

	function automatic len_info_t len_info(input logic [4:0] len);
		len_info_t r;
		r = '{first: '0, count: '0, offset: '0};
		case (len)
			5'd5:  r = '{30'h0,        9'd10, 9'd0};
			5'd6:  r = '{30'h14,       9'd26, 9'd10};
			5'd7:  r = '{30'h5c,       9'd32, 9'd36};
			5'd8:  r = '{30'hf8,       9'd6,  9'd68};
			5'd10: r = '{30'h3f8,      9'd5,  9'd74};
			5'd11: r = '{30'h7fa,      9'd3,  9'd79};
			5'd12: r = '{30'hffa,      9'd2,  9'd82};
			5'd13: r = '{30'h1ff8,     9'd6,  9'd84};
			5'd14: r = '{30'h3ffc,     9'd2,  9'd90};
			5'd15: r = '{30'h7ffc,     9'd3,  9'd92};
			5'd19: r = '{30'h7fff0,    9'd3,  9'd95};
			5'd20: r = '{30'hfffe6,    9'd8,  9'd98};
			5'd21: r = '{30'h1fffdc,   9'd13, 9'd106};
			5'd22: r = '{30'h3fffd2,   9'd26, 9'd119};
			5'd23: r = '{30'h7fffd8,   9'd29, 9'd145};
			5'd24: r = '{30'hffffea,   9'd12, 9'd174};
			5'd25: r = '{30'h1ffffec,  9'd4,  9'd186};
			5'd26: r = '{30'h3ffffe0,  9'd15, 9'd190};
			5'd27: r = '{30'h7ffffde,  9'd19, 9'd205};
			5'd28: r = '{30'hfffffe2,  9'd29, 9'd224};
			5'd30: r = '{30'h3ffffffc, 9'd4,  9'd253};
			default: r = '{first: '0, count: '0, offset: '0};
		endcase
		return r;
	endfunction

	// decoded octet by rank; the rank after the last entry is end of string
	localparam logic [7:0] SYM_TABLE [0:255] = '{
		8'd48, 8'd49, 8'd50, 8'd97, 8'd99, 8'd101, 8'd105, 8'd111, 8'd115, 8'd116,
		8'd32, 8'd37, 8'd45, 8'd46, 8'd47, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
		8'd56, 8'd57, 8'd61, 8'd65, 8'd95, 8'd98, 8'd100, 8'd102, 8'd103, 8'd104,
		8'd108, 8'd109, 8'd110, 8'd112, 8'd114, 8'd117,
		8'd58, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74,
		8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
		8'd85, 8'd86, 8'd87, 8'd89, 8'd106, 8'd107, 8'd113, 8'd118, 8'd119, 8'd120,
		8'd121, 8'd122,
		8'd38, 8'd42, 8'd44, 8'd59, 8'd88, 8'd90,
		8'd33, 8'd34, 8'd40, 8'd41, 8'd63,
		8'd39, 8'd43, 8'd124,
		8'd35, 8'd62,
		8'd0, 8'd36, 8'd64, 8'd91, 8'd93, 8'd126,
		8'd94, 8'd125,
		8'd60, 8'd96, 8'd123,
		8'd92, 8'd195, 8'd208,
		8'd128, 8'd130, 8'd131, 8'd162, 8'd184, 8'd194, 8'd224, 8'd226,
		8'd153, 8'd161, 8'd167, 8'd172, 8'd176, 8'd177, 8'd179, 8'd209, 8'd216, 8'd217,
		8'd227, 8'd229, 8'd230,
		8'd129, 8'd132, 8'd133, 8'd134, 8'd136, 8'd146, 8'd154, 8'd156, 8'd160, 8'd163,
		8'd164, 8'd169, 8'd170, 8'd173, 8'd178, 8'd181, 8'd185, 8'd186, 8'd187, 8'd189,
		8'd190, 8'd196, 8'd198, 8'd228, 8'd232, 8'd233,
		8'd1, 8'd135, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd143, 8'd147, 8'd149,
		8'd150, 8'd151, 8'd152, 8'd155, 8'd157, 8'd158, 8'd165, 8'd166, 8'd168, 8'd174,
		8'd175, 8'd180, 8'd182, 8'd183, 8'd188, 8'd191, 8'd197, 8'd231, 8'd239,
		8'd9, 8'd142, 8'd144, 8'd145, 8'd148, 8'd159, 8'd171, 8'd206, 8'd215, 8'd225,
		8'd236, 8'd237,
		8'd199, 8'd207, 8'd234, 8'd235,
		8'd192, 8'd193, 8'd200, 8'd201, 8'd202, 8'd205, 8'd210, 8'd213, 8'd218, 8'd219,
		8'd238, 8'd240, 8'd242, 8'd243, 8'd255,
		8'd203, 8'd204, 8'd211, 8'd212, 8'd214, 8'd221, 8'd222, 8'd223, 8'd241, 8'd244,
		8'd245, 8'd246, 8'd247, 8'd248, 8'd250, 8'd251, 8'd252, 8'd253, 8'd254,
		8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12, 8'd14,
		8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd23, 8'd24, 8'd25,
		8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd127, 8'd220, 8'd249,
		8'd10, 8'd13, 8'd22
	};

endpackage

// ===== sv/hpack_huffman_string_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_huffman_string_decoder
// Bit-serial decoder of huffman coded hpack string literals.
// ----------------------------------------------------------------------------
// One coded byte is taken per input beat and walked one bit per cycle, while the
// output does not stall, through a single canonical-code compare unit (subtract
// of the first code of the current length, compare against the code count, rank
// lookup). A byte passes an accept step, its bit steps and a closing step, with
// fewer bit steps when an error stops the walk early. A decoded octet is held
// back until the next one appears or the byte closes, so that the final output
// beat of a string carries last, status and decoded_count. Output stalls
// stretch the byte. Configuration beats are always taken and must come while
// idle.
`include "hpack_huffman_string_decoder_macros.svh"

module hpack_huffman_string_decoder #(
	parameter int LEN_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LEN_WIDTH-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           byte_in,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           symbol,
	output logic                 symbol_valid,
	output logic                 last,
	output logic [2:0]           status,
	output logic [LEN_WIDTH-1:0] decoded_count
);
	import hpd_pkg::*;

	localparam int CNT_W = LEN_WIDTH + 1;
	localparam logic [LEN_WIDTH-1:0] LEN_RESET =
		(LEN_WIDTH > 12) ? LEN_WIDTH'(4096) : '1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_BITS = 2'd1;
	localparam logic [1:0] S_END  = 2'd2;

	logic [1:0]           state_q;
	logic [LEN_WIDTH-1:0] max_len_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic [2:0]           bit_cnt_q;
	logic [CODE_BITS-1:0] code_q;
	logic [4:0]           len_q;
	logic [CNT_W-1:0]     in_cnt_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic [2:0]           err_q;
	logic [7:0]           pend_sym_q;
	logic                 pend_v_q;
	logic                 out_valid_q;
	logic [7:0]           out_sym_q;
	logic                 out_sv_q;
	logic                 out_last_q;
	logic [2:0]           out_status_q;
	logic [LEN_WIDTH-1:0] out_cnt_field_q;

	// shared bit step unit
	logic [CODE_BITS-1:0] nxt_code;
	logic [4:0]           nxt_len;
	len_info_t            info;
	logic [CODE_BITS-1:0] diff;
	logic                 hit;
	logic [8:0]           rank;
	logic                 is_eos;
	logic [7:0]           dec_sym;
	logic [CNT_W-1:0]     max_ext;
	logic                 out_full;
	logic                 out_space;
	logic                 step_push;
	logic                 stall;
	logic [CODE_BITS-1:0] pad_mask;
	logic                 pad_bad;
	logic [2:0]           fin_status;

	always_comb begin
		nxt_code  = {code_q[CODE_BITS-2:0], byte_q[7]};
		nxt_len   = len_q + 5'd1;
		info      = len_info(nxt_len);
		diff      = nxt_code - info.first;
		hit       = diff < CODE_BITS'(info.count);
		rank      = info.offset + diff[8:0];
		is_eos    = hit && (rank == EOS_RANK);
		dec_sym   = SYM_TABLE[rank[7:0]];
		max_ext   = CNT_W'(max_len_q);
		out_full  = (out_cnt_q >= max_ext);
		out_space = !out_valid_q || out_ready;
		step_push = hit && !is_eos && !out_full && pend_v_q;
		stall     = step_push && !out_space;
	end

	// padding check at the end of a string
	always_comb begin
		pad_mask = (CODE_BITS'(1) << len_q) - CODE_BITS'(1);
		pad_bad  = (len_q > 5'(MAX_PAD)) || (code_q != pad_mask);
		if (err_q != ST_OK) begin
			fin_status = err_q;
		end else if (pad_bad) begin
			fin_status = ST_PADDING;
		end else begin
			fin_status = ST_OK;
		end
	end

	assign cfg_ready     = 1'b1;
	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign symbol        = out_sym_q;
	assign symbol_valid  = out_sv_q;
	assign last          = out_last_q;
	assign status        = out_status_q;
	assign decoded_count = out_cnt_field_q;

	// sequencer and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			max_len_q       <= LEN_RESET;
			byte_q          <= '0;
			last_q          <= 1'b0;
			bit_cnt_q       <= '0;
			code_q          <= '0;
			len_q           <= '0;
			in_cnt_q        <= '0;
			out_cnt_q       <= '0;
			err_q           <= ST_OK;
			pend_sym_q      <= '0;
			pend_v_q        <= 1'b0;
			out_valid_q     <= 1'b0;
			out_sym_q       <= '0;
			out_sv_q        <= 1'b0;
			out_last_q      <= 1'b0;
			out_status_q    <= ST_OK;
			out_cnt_field_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q    <= byte_in;
						last_q    <= last_byte;
						bit_cnt_q <= '0;
						if (err_q != ST_OK) begin
							state_q <= S_END;
						end else if (in_cnt_q >= max_ext) begin
							err_q   <= ST_IN_LEN;
							state_q <= S_END;
						end else begin
							in_cnt_q <= in_cnt_q + CNT_W'(1);
							state_q  <= S_BITS;
						end
					end
				end
				S_BITS: begin
					if (!stall) begin
						byte_q    <= {byte_q[6:0], 1'b0};
						bit_cnt_q <= bit_cnt_q + 3'd1;
						if (bit_cnt_q == 3'd7) begin
							state_q <= S_END;
						end
						if (is_eos) begin
							err_q   <= ST_EOS;
							state_q <= S_END;
						end else if (hit) begin
							if (out_full) begin
								err_q   <= ST_OUT_LEN;
								state_q <= S_END;
							end else begin
								// older octet moves to the output register
								if (pend_v_q) begin
									out_valid_q     <= 1'b1;
									out_sym_q       <= pend_sym_q;
									out_sv_q        <= 1'b1;
									out_last_q      <= 1'b0;
									out_status_q    <= ST_OK;
									out_cnt_field_q <= '0;
								end
								pend_sym_q <= dec_sym;
								pend_v_q   <= 1'b1;
								out_cnt_q  <= out_cnt_q + CNT_W'(1);
								code_q     <= '0;
								len_q      <= '0;
							end
						end else begin
							code_q <= nxt_code;
							len_q  <= nxt_len;
							if (nxt_len >= 5'(CODE_BITS)) begin
								err_q   <= ST_EOS;
								state_q <= S_END;
							end
						end
					end
				end
				S_END: begin
					if (last_q) begin
						if (out_space) begin
							out_valid_q     <= 1'b1;
							out_sym_q       <= pend_v_q ? pend_sym_q : 8'd0;
							out_sv_q        <= pend_v_q;
							out_last_q      <= 1'b1;
							out_status_q    <= fin_status;
							out_cnt_field_q <= out_cnt_q[LEN_WIDTH-1:0];
							pend_v_q        <= 1'b0;
							code_q          <= '0;
							len_q           <= '0;
							in_cnt_q        <= '0;
							out_cnt_q       <= '0;
							err_q           <= ST_OK;
							state_q         <= S_IDLE;
						end
					end else if (pend_v_q) begin
						if (out_space) begin
							out_valid_q     <= 1'b1;
							out_sym_q       <= pend_sym_q;
							out_sv_q        <= 1'b1;
							out_last_q      <= 1'b0;
							out_status_q    <= ST_OK;
							out_cnt_field_q <= '0;
							pend_v_q        <= 1'b0;
							state_q         <= S_IDLE;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`HPD_ASSERT_NOW(a_idle_no_pending, state_q == S_IDLE, !pend_v_q)
	`HPD_ASSERT_NOW(a_bits_len_bound, state_q == S_BITS, len_q < 5'(CODE_BITS))
	`HPD_ASSERT_NOW(a_empty_is_last, out_valid_q && !out_sv_q, out_last_q)
	`HPD_ASSERT_NEXT(a_err_stops_bits, state_q == S_BITS && err_q != ST_OK, state_q != S_BITS)

endmodule

// ===== sim/tb_hpack_huffman_string_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hpack_huffman_string_decoder
// Self-checking bench for the bit-serial hpack huffman string decoder.
// ----------------------------------------------------------------------------
// Coded strings are built from a canonical code table that is rebuilt here from
// the code lengths. Most strings are well formed. The rest carry an end of
// string code, bad padding or random noise. A behavioral decoder predicts every
// output beat. The bench runs through several string length limits, and both
// sides idle at random.
module tb_hpack_huffman_string_decoder;
	import hpd_pkg::*;

	localparam int LW         = 16;
	localparam int SETTLE_CYC = 40;
	localparam int CYCLE_CAP  = 600000;
	localparam int NUM_SYMS   = 257;
	localparam int EOS_CODE   = 256;

	typedef struct {
		logic [7:0] data;
		logic       fin;
	} coded_byte_t;

	typedef struct {
		logic [7:0]    sym;
		logic          sym_ok;
		logic          fin;
		logic [2:0]    st;
		logic [LW-1:0] count;
	} octet_beat_t;

	// code length of each symbol, end of string code last
	localparam byte CODE_LEN [0:NUM_SYMS-1] = '{
		13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
		28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
		6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
		5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
		13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
		7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
		15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
		6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
		20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
		24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
		22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
		21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
		26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
		19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
		20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
		26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26,
		30
	};

	logic          clk;
	logic          arst_n;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [LW-1:0] cfg_data;
	logic          in_valid;
	logic          in_ready;
	logic [7:0]    byte_in;
	logic          last_byte;
	logic          out_valid;
	logic          out_ready;
	logic [7:0]    symbol;
	logic          symbol_valid;
	logic          last;
	logic [2:0]    status;
	logic [LW-1:0] decoded_count;

	hpack_huffman_string_decoder #(.LEN_WIDTH(LW)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.symbol        (symbol),
		.symbol_valid  (symbol_valid),
		.last          (last),
		.status        (status),
		.decoded_count (decoded_count)
	);

	logic [29:0]  code_word [0:NUM_SYMS-1];
	coded_byte_t  byte_queue[$];
	octet_beat_t  octets_due[$];
	bit           bitbuf[$];
	int           in_gap;
	int           out_wait;
	int           hold_left;
	int           octets_seen;
	int           mismatches;
	int           cycles;
	bit           gaps_on;
	bit           hold_done;

	// decoder state as predicted
	logic [LW-1:0] lim;
	logic [29:0]   acc_code;
	int            acc_len;
	int            taken;
	int            made;
	logic [2:0]    first_err;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// canonical codes: ascending length, then ascending symbol
	function automatic void build_codes();
		logic [29:0] c;
		c = '0;
		for (int l = 1; l <= 30; l++) begin
			for (int s = 0; s < NUM_SYMS; s++) begin
				if (CODE_LEN[s] == l) begin
					code_word[s] = c;
					c++;
				end
			end
			c = c << 1;
		end
	endfunction

	function automatic int match_code(logic [29:0] c, int l);
		for (int s = 0; s < NUM_SYMS; s++)
			if (CODE_LEN[s] == l && code_word[s] == c)
				return s;
		return -1;
	endfunction

	function automatic void clear_string();
		acc_code  = '0;
		acc_len   = 0;
		taken     = 0;
		made      = 0;
		first_err = ST_OK;
	endfunction

	// predicts the output beats of one coded byte
	function automatic void decode_byte(logic [7:0] b, logic fin);
		octet_beat_t r;
		int n;
		int s;
		n = 0;
		if (first_err == ST_OK) begin
			if (taken >= lim) begin
				first_err = ST_IN_LEN;
			end else begin
				taken++;
				for (int k = 7; k >= 0 && first_err == ST_OK; k--) begin
					acc_code = {acc_code[28:0], b[k]};
					acc_len++;
					s = match_code(acc_code, acc_len);
					if (s == EOS_CODE) begin
						first_err = ST_EOS;
					end else if (s >= 0) begin
						if (made >= lim) begin
							first_err = ST_OUT_LEN;
						end else begin
							r = '{sym: s[7:0], sym_ok: 1'b1, fin: 1'b0, st: ST_OK, count: '0};
							octets_due.push_back(r);
							n++;
							made++;
							acc_code = '0;
							acc_len  = 0;
						end
					end else if (acc_len >= 30) begin
						first_err = ST_EOS;
					end
				end
			end
		end
		if (fin) begin
			if (first_err == ST_OK &&
					(acc_len > MAX_PAD || acc_code != (30'h1 << acc_len) - 30'h1))
				first_err = ST_PADDING;
			if (n == 0) begin
				r = '{sym: '0, sym_ok: 1'b0, fin: 1'b0, st: ST_OK, count: '0};
				octets_due.push_back(r);
			end
			octets_due[$].fin   = 1'b1;
			octets_due[$].st    = first_err;
			octets_due[$].count = made[LW-1:0];
			clear_string();
		end
	endfunction

	// string building
	function automatic void push_code(int s);
		for (int k = CODE_LEN[s] - 1; k >= 0; k--)
			bitbuf.push_back(code_word[s][k]);
	endfunction

	function automatic void flush_string(bit pad_one);
		coded_byte_t cb;
		while (bitbuf.size() % 8 != 0)
			bitbuf.push_back(pad_one);
		if (bitbuf.size() == 0)
			for (int k = 0; k < 8; k++)
				bitbuf.push_back(1'b1);
		while (bitbuf.size() > 0) begin
			for (int k = 7; k >= 0; k--)
				cb.data[k] = bitbuf.pop_front();
			cb.fin = (bitbuf.size() == 0);
			byte_queue.push_back(cb);
		end
	endfunction

	function automatic void push_raw(logic [7:0] b, logic fin);
		coded_byte_t cb;
		cb.data = b;
		cb.fin  = fin;
		byte_queue.push_back(cb);
	endfunction

	function automatic int pick_sym();
		int p;
		p = $urandom_range(0, 9);
		if (p < 6)
			return $urandom_range(32, 126);
		return $urandom_range(0, 255);
	endfunction

	function automatic void add_string();
		int kind;
		int n;
		kind = $urandom_range(0, 19);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
		for (int k = 0; k < n; k++)
			push_code(pick_sym());
		if (kind < 14) begin
			flush_string(1'b1);
		end else if (kind == 14) begin
			// end of string code inside the payload
			push_code(EOS_CODE);
			push_code(pick_sym());
			flush_string(1'b1);
		end else if (kind == 15) begin
			// zero bits in the padding
			flush_string(1'b0);
		end else if (kind == 16) begin
			// a whole byte of padding
			for (int k = 0; k < 8; k++)
				bitbuf.push_back(1'b1);
			flush_string(1'b1);
		end else begin
			bitbuf.delete();
			n = $urandom_range(1, 6);
			for (int k = 0; k < n; k++)
				push_raw(8'($urandom_range(0, 255)), k == n - 1);
		end
	endfunction

	// directed strings: extremes, end of string code, padding cases, two octets
	function automatic void add_directed();
		push_raw(8'hff, 1'b1);
		push_raw(8'h00, 1'b1);
		push_raw(8'h07, 1'b1);
		for (int k = 0; k < 4; k++)
			push_raw(8'hff, k == 3);
		push_code(97);
		flush_string(1'b1);
		push_code(48);
		push_code(48);
		push_code(48);
		flush_string(1'b1);
		push_code(10);
		push_code(255);
		flush_string(1'b1);
		push_code(EOS_CODE);
		flush_string(1'b1);
		push_code(120);
		flush_string(1'b0);
		push_raw(8'h00, 1'b0);
		push_raw(8'h00, 1'b1);
	endfunction

	// stimulus side: one coded byte per beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			byte_in   <= '0;
			last_byte <= 1'b0;
			in_gap    <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_gap > 0) begin
				in_gap   <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (byte_queue.size() > 0) begin
				byte_in   <= byte_queue[0].data;
				last_byte <= byte_queue[0].fin;
				void'(byte_queue.pop_front());
				in_valid  <= 1'b1;
				in_gap    <= gaps_on ? $urandom_range(0, 4) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long output hold-off, once, while input keeps coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && octets_seen >= 150) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end
	end

	// output side ready
	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait  <= 0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			w = gaps_on ? $urandom_range(0, 4) : 0;
			out_wait  <= (w > 0) ? w - 1 : 0;
			out_ready <= (w == 0);
		end else if (out_wait > 0) begin
			out_wait  <= out_wait - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: predict on accepted input, compare accepted output beats
	always @(posedge clk) begin
		octet_beat_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				lim = cfg_data;
			if (in_valid && in_ready)
				decode_byte(byte_in, last_byte);
			if (out_valid && out_ready) begin
				octets_seen <= octets_seen + 1;
				if (octets_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: sym %0d ok %0d last %0d st %0d cnt %0d",
							symbol, symbol_valid, last, status, decoded_count);
				end else begin
					e = octets_due.pop_front();
					if (symbol !== e.sym || symbol_valid !== e.sym_ok || last !== e.fin ||
							status !== e.st || decoded_count !== e.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp sym %0d ok %0d last %0d st %0d cnt %0d, ",
								e.sym, e.sym_ok, e.fin, e.st, e.count,
								"got sym %0d ok %0d last %0d st %0d cnt %0d",
								symbol, symbol_valid, last, status, decoded_count);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_CAP) begin
			$display("[hpack_huffman_string_decoder] ERROR");
			$finish;
		end
	end

	task automatic wait_idle();
		while (byte_queue.size() > 0 || in_valid || octets_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_limit(logic [LW-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// phases over length limits
	initial begin
		logic [LW-1:0] limits [0:6];
		limits = '{16'd4096, 16'd65535, 16'd3, 16'd0, 16'd1, 16'd24, 16'd4096};
		build_codes();
		lim         = 16'd4096;
		clear_string();
		mismatches  = 0;
		octets_seen = 0;
		cycles      = 0;
		gaps_on     = 1'b1;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_directed();
		for (int ph = 0; ph < 7; ph++) begin
			if (ph > 0)
				write_limit(ph == 6 ? LW'($urandom_range(2, 200)) : limits[ph]);
			gaps_on = (ph != 2);
			while (byte_queue.size() < 230)
				add_string();
			wait_idle();
		end
		if (mismatches == 0)
			$display("[hpack_huffman_string_decoder] OK");
		else
			$display("[hpack_huffman_string_decoder] ERROR");
		$finish;
	end

endmodule
